// File: hw/rtl/etf_pkg.sv
// etf_pkg: shared widths, constants, register indexes and the job type
// for the escape-time fractal pixel block. No dependencies.

package etf_pkg;

  localparam int unsigned DATA_W     = 32;   // signed q4.28
  localparam int unsigned FRAC_W     = 28;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned FACTOR_W   = 8;
  localparam int unsigned COLOR_W    = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned MAX_ITER   = 256;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONV_COLOR = 2'd2;

  localparam logic [CNT_W-1:0]    MAX_ITER_RST   = 9'd100;
  localparam logic [FACTOR_W-1:0] FACTOR_RST     = 8'd1;
  localparam logic [COLOR_W-1:0]  CONV_COLOR_RST = 32'hff00_0000;

  localparam logic [7:0] ALPHA_BYTE = 8'hff;

  // |z|^2 > 4 in q8.56
  localparam logic [2*DATA_W-1:0] MAG_LIMIT = 64'h0400_0000_0000_0000;

  // color split: n / 255 and n / 15 by reciprocal multiply plus one correction
  localparam int unsigned N_W         = CNT_W + FACTOR_W;
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned DIV_255     = 255;
  localparam int unsigned DIV_15      = 15;
  localparam int unsigned RECIP_255   = 257;
  localparam int unsigned RECIP_15    = 4369;
  localparam int unsigned P255_W      = N_W + 9;
  localparam int unsigned P15_W       = N_W + 13;
  localparam int unsigned Q255_W      = P255_W - RECIP_SHIFT;
  localparam int unsigned Q15_W       = P15_W - RECIP_SHIFT;

  typedef struct packed {
    logic signed [DATA_W-1:0] c_re;
    logic signed [DATA_W-1:0] c_im;
    logic signed [DATA_W-1:0] z_re;
    logic signed [DATA_W-1:0] z_im;
    logic [CNT_W-1:0]         count;
    logic [CNT_W-1:0]         limit;
  } job_t;

endpackage

// File: hw/rtl/etf_if.sv
// etf_pix_if / etf_res_if: valid-ready channels for points in and results out.
// Depends on etf_pkg for field widths.

interface etf_pix_if import etf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] c_re;
  logic signed [DATA_W-1:0] c_im;
  logic signed [DATA_W-1:0] z_re;
  logic signed [DATA_W-1:0] z_im;
  logic [CNT_W-1:0]         start_count;

  modport source (output valid, c_re, c_im, z_re, z_im, start_count, input ready);
  modport sink   (input valid, c_re, c_im, z_re, z_im, start_count, output ready);
endinterface

interface etf_res_if import etf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CNT_W-1:0]   iterations;
  logic               converged;
  logic [COLOR_W-1:0] color;

  modport source (output valid, iterations, converged, color, input ready);
  modport sink   (input valid, iterations, converged, color, output ready);
endinterface

// File: hw/rtl/etf_front.sv
// etf_front: input register stage; takes point transfers and attaches the
// effective iteration limit. Depends on etf_pkg and etf_pix_if.

module etf_front import etf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  etf_pix_if.sink          pix_i,
  input  logic [CNT_W-1:0] max_iter_i,
  output logic             job_valid_o,
  input  logic             job_ready_i,
  output job_t             job_o
);

  logic             vld_q;
  job_t             job_q;
  logic [CNT_W-1:0] limit;

  // limit is capped at the hardware maximum
  always_comb begin
    if (32'(max_iter_i) > MAX_ITER) begin
      limit = CNT_W'(MAX_ITER);
    end else begin
      limit = max_iter_i;
    end
  end

  assign pix_i.ready = !vld_q || job_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (pix_i.ready) begin
      vld_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_i.valid && pix_i.ready) begin
      job_q.c_re  <= pix_i.c_re;
      job_q.c_im  <= pix_i.c_im;
      job_q.z_re  <= pix_i.z_re;
      job_q.z_im  <= pix_i.z_im;
      job_q.count <= pix_i.start_count;
      job_q.limit <= limit;
    end
  end

  assign job_valid_o = vld_q;
  assign job_o       = job_q;

endmodule

// File: hw/rtl/etf_queue.sv
// etf_queue: small fifo of jobs between front and back end.
// Depends on etf_pkg for the job type.

module etf_queue import etf_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_valid_i,
  output logic                       push_ready_o,
  input  job_t                       push_data_i,
  output logic                       pop_valid_o,
  input  logic                       pop_ready_i,
  output job_t                       pop_data_o,
  output logic [$clog2(Depth+1)-1:0] occ_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned OccW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [OccW-1:0] occ_q, occ_d;
  logic            push, pop;

  assign push_ready_o = occ_q != OccW'(Depth);
  assign pop_valid_o  = occ_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign occ_o        = occ_q;

  always_comb begin
    occ_d = occ_q;
    if (push && !pop) begin
      occ_d = occ_q + 1'b1;
    end else if (pop && !push) begin
      occ_d = occ_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      occ_q    <= '0;
    end else begin
      occ_q <= occ_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: hw/rtl/etf_back.sv
// etf_back: iteration engine (z = z*z + c, a multiply state and an add state per
// update), color split and output register. Depends on etf_pkg and etf_res_if.

module etf_back import etf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  job_t                job_i,
  input  logic [FACTOR_W-1:0] color_factor_i,
  input  logic [COLOR_W-1:0]  conv_color_i,
  etf_res_if.source           res_o
);

  localparam int unsigned SUM_W = DATA_W + 8;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ADD, ST_CMUL, ST_CDIV, ST_COUT
  } state_e;

  state_e state_q, state_d;

  logic signed [DATA_W-1:0]   zr_q, zi_q, cr_q, ci_q;
  logic [CNT_W-1:0]           cnt_q, lim_q;
  logic                       first_q, conv_q;
  logic signed [2*DATA_W-1:0] pxx_q, pyy_q, pxy_q;
  logic [2*DATA_W-1:0]        mag;
  logic signed [SUM_W-1:0]    sum_re, sum_im;
  logic                       diverged, stop_conv, cont;

  logic [N_W-1:0]     n_q;
  logic [Q255_W-1:0]  q255_q, q255_fix;
  logic [Q15_W-1:0]   q15_q, q15_fix;
  logic [P255_W-1:0]  p255;
  logic [P15_W-1:0]   p15;
  logic [N_W:0]       rem255, rem15;
  logic [COLOR_W-1:0] color;
  logic               out_free;

  logic               out_vld_q;
  logic [CNT_W-1:0]   out_iter_q;
  logic               out_conv_q;
  logic [COLOR_W-1:0] out_color_q;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi, lo;
    hi = SUM_W'({1'b0, {(DATA_W-1){1'b1}}});
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

  // products are floored by the arithmetic shift; cross term doubled
  always_comb begin
    mag    = $unsigned(pxx_q) + $unsigned(pyy_q);
    sum_re = SUM_W'(pxx_q >>> FRAC_W) - SUM_W'(pyy_q >>> FRAC_W) + SUM_W'(cr_q);
    sum_im = SUM_W'(pxy_q >>> (FRAC_W - 1)) + SUM_W'(ci_q);
    // first pass has no updated z to test yet
    diverged  = !first_q && (mag > MAG_LIMIT);
    stop_conv = !first_q && !diverged && (cnt_q >= lim_q);
    cont      = !diverged && !stop_conv;
  end

  // color split with one correction step per quotient
  always_comb begin
    p255     = P255_W'(n_q) * P255_W'(RECIP_255);
    p15      = P15_W'(n_q) * P15_W'(RECIP_15);
    rem255   = (N_W+1)'(n_q) - (N_W+1)'(q255_q) * (N_W+1)'(DIV_255);
    rem15    = (N_W+1)'(n_q) - (N_W+1)'(q15_q) * (N_W+1)'(DIV_15);
    q255_fix = q255_q + Q255_W'(rem255 >= (N_W+1)'(DIV_255));
    q15_fix  = q15_q + Q15_W'(rem15 >= (N_W+1)'(DIV_15));
    if (conv_q) begin
      color = conv_color_i;
    end else begin
      color = {ALPHA_BYTE, q255_fix[7:0], q15_fix[7:0], n_q[7:0]};
    end
  end

  assign out_free    = !out_vld_q || res_o.ready;
  assign job_ready_o = state_q == ST_IDLE;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_ADD;
      ST_ADD: begin
        state_d = cont ? ST_MUL : ST_CMUL;
      end
      ST_CMUL: state_d = ST_CDIV;
      ST_CDIV: state_d = ST_COUT;
      ST_COUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_vld_q   <= 1'b0;
      out_iter_q  <= '0;
      out_conv_q  <= 1'b0;
      out_color_q <= '0;
    end else begin
      state_q <= state_d;
      if (out_vld_q && res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (state_q == ST_COUT && out_free) begin
        out_vld_q   <= 1'b1;
        out_iter_q  <= cnt_q;
        out_conv_q  <= conv_q;
        out_color_q <= color;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          zr_q    <= job_i.z_re;
          zi_q    <= job_i.z_im;
          cr_q    <= job_i.c_re;
          ci_q    <= job_i.c_im;
          cnt_q   <= job_i.count;
          lim_q   <= job_i.limit;
          first_q <= 1'b1;
          conv_q  <= 1'b0;
        end
      end
      ST_MUL: begin
        pxx_q <= zr_q * zr_q;
        pyy_q <= zi_q * zi_q;
        pxy_q <= zr_q * zi_q;
      end
      ST_ADD: begin
        if (stop_conv) begin
          conv_q <= 1'b1;
        end
        if (cont) begin
          if (!first_q) begin
            cnt_q <= cnt_q + 1'b1;
          end
          zr_q    <= sat32(sum_re);
          zi_q    <= sat32(sum_im);
          first_q <= 1'b0;
        end
      end
      ST_CMUL: begin
        n_q <= N_W'(cnt_q) * N_W'(color_factor_i);
      end
      ST_CDIV: begin
        q255_q <= p255[P255_W-1:RECIP_SHIFT];
        q15_q  <= p15[P15_W-1:RECIP_SHIFT];
      end
      default: ;
    endcase
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.iterations = out_iter_q;
  assign res_o.converged  = out_conv_q;
  assign res_o.color      = out_color_q;

endmodule

// File: hw/rtl/escape_time_fractal_pixel.sv
// escape_time_fractal_pixel: top level with configuration registers, front
// stage, job queue and iteration back end. Depends on etf_pkg and etf_if.

// Computes the escape-time count of one point (Mandelbrot or Julia) in signed
// q4.28 and turns it into an ARGB color. The back end's complex square-and-add
// unit makes s updates of z for a point, then one last pass that tests the
// final z; the point also passes the front register, queue, job load, color
// split and output register. s is at most the limit minus start_count plus one.
// The back end holds one point at a time; the front register and the queue hold
// up to QueueDepth + 1 more. A finished result waits in the output register and
// the next point iterates meanwhile, stalling at output until it is taken.

module escape_time_fractal_pixel import etf_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  etf_pix_if.sink              pix_i,
  etf_res_if.source            res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COLOR_W-1:0]   cfg_wdata_i
);

  localparam int unsigned OccW = $clog2(QueueDepth + 1);

  logic [CNT_W-1:0]    max_iter_q;
  logic [FACTOR_W-1:0] factor_q;
  logic [COLOR_W-1:0]  conv_color_q;

  logic            fr_valid, fr_ready;
  job_t            fr_job;
  logic            bk_valid, bk_ready;
  job_t            bk_job;
  logic [OccW-1:0] q_occ;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q   <= MAX_ITER_RST;
      factor_q     <= FACTOR_RST;
      conv_color_q <= CONV_COLOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_ITER:   max_iter_q   <= cfg_wdata_i[CNT_W-1:0];
        CFG_FACTOR:     factor_q     <= cfg_wdata_i[FACTOR_W-1:0];
        CFG_CONV_COLOR: conv_color_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  etf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_i),
    .max_iter_i  (max_iter_q),
    .job_valid_o (fr_valid),
    .job_ready_i (fr_ready),
    .job_o       (fr_job)
  );

  etf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_job),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_job),
    .occ_o        (q_occ)
  );

  etf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (bk_valid),
    .job_ready_o    (bk_ready),
    .job_i          (bk_job),
    .color_factor_i (factor_q),
    .conv_color_i   (conv_color_q),
    .res_o          (res_o)
  );

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_occ <= OccW'(QueueDepth))
    else $error("job queue over depth");

  // occupancy moves by at most one per cycle
  a_queue_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_occ != $past(q_occ) |-> (q_occ == $past(q_occ) + 1'b1 ||
                                q_occ + 1'b1 == $past(q_occ)))
    else $error("job queue occupancy jumped");

  // diverged points always carry an opaque alpha
  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.converged |-> res_o.color[31:24] == ALPHA_BYTE)
    else $error("diverged result without opaque alpha");

endmodule
